FILE: hdl/sgd_pkg.sv
// Shared constants and types for the Sobel gradient and direction block.
// Used by every module of the block except sgd_ram, and by its checker; depends on nothing else.
`default_nettype none

package sgd_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MIN_WIDTH   = 3;
    localparam int RESET_WIDTH = 512;
    localparam int LINE_LEN    = MAX_WIDTH + 2;
    localparam int LS_AW       = $clog2(LINE_LEN);

    localparam int PIX_W = 8;
    localparam int CNT_W = 11;
    localparam int MAG_W = 11;
    localparam int DIR_W = 2;
    localparam int SOB_W = 11;
    localparam int ABS_W = 10;
    localparam int SUM_W = ABS_W + 1;
    localparam int SQ_W  = 2 * SUM_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int OUT_DEPTH   = 8;
    localparam int OUT_AW      = $clog2(OUT_DEPTH);

    typedef enum logic [DIR_W-1:0] {
        DIR_HORIZONTAL = 2'd0,
        DIR_DIAG_SAME  = 2'd1,
        DIR_VERTICAL   = 2'd2,
        DIR_DIAG_OPP   = 2'd3
    } dir_t;

    // One classified pixel request on its way from the front end to the back end.
    typedef struct packed {
        logic [PIX_W-1:0] cur;
        logic [LS_AW-1:0] addr;
        logic             emit;
        logic             last;
    } item_t;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        dir_t             dir;
        logic             last;
    } result_t;

endpackage

`default_nettype wire

FILE: hdl/sgd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Self-contained; no package needed.
`default_nettype none

module sgd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sgd_front.sv
// Front end: holds the frame width, tracks the padded raster position and classifies
// each accepted pixel. Depends on sgd_pkg.
`default_nettype none

module sgd_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [sgd_pkg::PIX_W-1:0] pixel,
    input  logic                      pixel_valid,
    output logic                      pixel_stall,
    input  logic                      cfg_write,
    input  logic [sgd_pkg::CNT_W-1:0] frame_width,
    input  logic                      q_full,
    output logic                      push,
    output sgd_pkg::item_t            push_item
);

    import sgd_pkg::*;

    logic [CNT_W-1:0] width_reg;
    logic [CNT_W-1:0] col_reg;
    logic [CNT_W-1:0] row_reg;
    logic [CNT_W-1:0] col_next;
    logic [CNT_W-1:0] row_next;
    logic [CNT_W-1:0] width_clamped;
    logic [CNT_W-1:0] edge_pos;
    logic             in_frame;

    always_comb
    begin
        if (frame_width < CNT_W'(MIN_WIDTH))
        begin
            width_clamped = CNT_W'(MIN_WIDTH);
        end
        else if (frame_width > CNT_W'(MAX_WIDTH))
        begin
            width_clamped = CNT_W'(MAX_WIDTH);
        end
        else
        begin
            width_clamped = frame_width;
        end
    end

    assign pixel_stall = q_full;
    assign push        = pixel_valid && !q_full;

    // Last padded index in both directions is width + 1.
    assign edge_pos = CNT_W'(width_reg + CNT_W'(1));
    assign in_frame = (row_reg < width_reg) && (col_reg < width_reg);

    always_comb
    begin
        push_item.cur  = in_frame ? pixel : '0;
        push_item.addr = col_reg[LS_AW-1:0];
        push_item.emit = (row_reg >= CNT_W'(2)) && (col_reg >= CNT_W'(2));
        push_item.last = (row_reg == edge_pos) && (col_reg == edge_pos);

        col_next = CNT_W'(col_reg + CNT_W'(1));
        row_next = row_reg;
        if (col_reg == edge_pos)
        begin
            col_next = '0;
            row_next = (row_reg == edge_pos) ? '0 : CNT_W'(row_reg + CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= CNT_W'(RESET_WIDTH);
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else if (cfg_write)
        begin
            width_reg <= width_clamped;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else if (push)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sgd_queue.sv
// Short request queue between the front end and the back end.
// Depends on sgd_pkg for the item type and depth.
`default_nettype none

module sgd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sgd_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output sgd_pkg::item_t head_item
);

    import sgd_pkg::*;

    item_t               mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;

    assign full       = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= QUEUE_AW'(wr_ptr_reg + QUEUE_AW'(1));
            end
            if (pop)
            begin
                rd_ptr_reg <= QUEUE_AW'(rd_ptr_reg + QUEUE_AW'(1));
            end
            if (push && !pop)
            begin
                count_reg <= (QUEUE_AW+1)'(count_reg + (QUEUE_AW+1)'(1));
            end
            else if (pop && !push)
            begin
                count_reg <= (QUEUE_AW+1)'(count_reg - (QUEUE_AW+1)'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sgd_back.sv
// Back end: line stores, 3x3 window, Sobel sums, direction sector tests and result buffer.
// Depends on sgd_pkg and sgd_ram.
`default_nettype none

module sgd_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      restart,
    input  logic                      q_valid,
    input  sgd_pkg::item_t            q_item,
    output logic                      pop,
    output logic                      idle,
    output logic                      result_valid,
    input  logic                      result_stall,
    output logic [sgd_pkg::MAG_W-1:0] magnitude_q2,
    output logic [sgd_pkg::DIR_W-1:0] direction_class,
    output logic                      frame_last
);

    import sgd_pkg::*;

    localparam int CRED_W = OUT_AW + 2;

    // Stage 1: line store data arrives, window shifts
    logic                   s1_valid_reg;
    item_t                  s1_item_reg;
    logic [2*PIX_W-1:0]     ram_rdata;
    logic [PIX_W-1:0]       up1;
    logic [PIX_W-1:0]       up2;
    logic [PIX_W-1:0]       win_reg  [9];
    logic [PIX_W-1:0]       win_next [9];
    logic signed [SOB_W-1:0] sx_c;
    logic signed [SOB_W-1:0] sy_c;

    // Stage 2: gradient sums
    logic                    s2_valid_reg;
    logic                    s2_last_reg;
    logic signed [SOB_W-1:0] s2_sx_reg;
    logic signed [SOB_W-1:0] s2_sy_reg;

    // Stage 3: squares for the sector tests
    logic [ABS_W-1:0]  abs_x;
    logic [ABS_W-1:0]  abs_y;
    logic [SUM_W-1:0]  sum_c;
    logic [ABS_W-1:0]  diff_c;
    logic              s3_valid_reg;
    logic              s3_last_reg;
    logic              s3_zero_reg;
    logic              s3_a_gt_b_reg;
    logic              s3_same_reg;
    logic [SUM_W-1:0]  s3_mag_reg;
    logic [SQ_W-1:0]   s3_ss_reg;
    logic [SQ_W-1:0]   s3_bb_reg;
    logic [SQ_W-1:0]   s3_dd_reg;
    logic [SQ_W-1:0]   bb2;
    dir_t              dir_c;

    // Result buffer
    result_t           out_mem_reg [OUT_DEPTH];
    logic [OUT_AW-1:0] out_wr_reg;
    logic [OUT_AW-1:0] out_rd_reg;
    logic [OUT_AW:0]   out_count_reg;
    logic [1:0]        inflight;
    logic              out_pop;
    result_t           out_head;

    function automatic logic signed [SOB_W-1:0] widen(input logic [PIX_W-1:0] p);
        return $signed({{(SOB_W-PIX_W){1'b0}}, p});
    endfunction

    // A request is released only when the buffer can hold every result already in flight.
    assign inflight = 2'((s1_valid_reg && s1_item_reg.emit)) + 2'(s2_valid_reg)
                    + 2'(s3_valid_reg);
    assign pop = q_valid
              && ((CRED_W'(out_count_reg) + CRED_W'(inflight)) < CRED_W'(OUT_DEPTH));
    assign idle = !s1_valid_reg && !s2_valid_reg && !s3_valid_reg && (out_count_reg == '0);

    sgd_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (LINE_LEN)
    ) u_line_store (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_item_reg.addr),
        .wdata ({up1, s1_item_reg.cur}),
        .re    (pop),
        .raddr (q_item.addr),
        .rdata (ram_rdata)
    );

    assign up2 = ram_rdata[2*PIX_W-1:PIX_W];
    assign up1 = ram_rdata[PIX_W-1:0];

    always_comb
    begin
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = up2;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = up1;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = s1_item_reg.cur;

        sx_c = (widen(win_next[2]) + (widen(win_next[5]) <<< 1) + widen(win_next[8]))
             - (widen(win_next[0]) + (widen(win_next[3]) <<< 1) + widen(win_next[6]));
        sy_c = (widen(win_next[0]) + (widen(win_next[1]) <<< 1) + widen(win_next[2]))
             - (widen(win_next[6]) + (widen(win_next[7]) <<< 1) + widen(win_next[8]));
    end

    always_comb
    begin
        abs_x  = s2_sx_reg[SOB_W-1] ? ABS_W'(-s2_sx_reg) : ABS_W'(s2_sx_reg);
        abs_y  = s2_sy_reg[SOB_W-1] ? ABS_W'(-s2_sy_reg) : ABS_W'(s2_sy_reg);
        sum_c  = SUM_W'(abs_x) + SUM_W'(abs_y);
        diff_c = ABS_W'(abs_x - abs_y);
    end

    // Sector tests against tan 22.5 and tan 67.5 in exact integer form.
    assign bb2 = SQ_W'({s3_bb_reg, 1'b0});

    always_comb
    begin
        if (s3_zero_reg || (s3_ss_reg < bb2))
        begin
            dir_c = DIR_HORIZONTAL;
        end
        else if (s3_a_gt_b_reg && (s3_dd_reg > bb2))
        begin
            dir_c = DIR_VERTICAL;
        end
        else if (s3_same_reg)
        begin
            dir_c = DIR_DIAG_SAME;
        end
        else
        begin
            dir_c = DIR_DIAG_OPP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            s1_valid_reg <= pop;
            s2_valid_reg <= s1_valid_reg && s1_item_reg.emit;
            s3_valid_reg <= s2_valid_reg;
            if (restart)
            begin
                for (int i = 0; i < 9; i++)
                begin
                    win_reg[i] <= '0;
                end
            end
            else if (s1_valid_reg)
            begin
                for (int i = 0; i < 9; i++)
                begin
                    win_reg[i] <= win_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_item_reg <= q_item;
        end
        if (s1_valid_reg)
        begin
            s2_sx_reg   <= sx_c;
            s2_sy_reg   <= sy_c;
            s2_last_reg <= s1_item_reg.last;
        end
        if (s2_valid_reg)
        begin
            s3_last_reg   <= s2_last_reg;
            s3_zero_reg   <= (abs_x == '0) && (abs_y == '0);
            s3_a_gt_b_reg <= abs_x > abs_y;
            s3_same_reg   <= ((s2_sx_reg > 0) == (s2_sy_reg > 0));
            s3_mag_reg    <= sum_c;
            s3_ss_reg     <= SQ_W'(sum_c) * SQ_W'(sum_c);
            s3_bb_reg     <= SQ_W'(abs_y) * SQ_W'(abs_y);
            s3_dd_reg     <= SQ_W'(diff_c) * SQ_W'(diff_c);
        end
    end

    // Result buffer
    assign out_pop      = result_valid && !result_stall;
    assign result_valid = (out_count_reg != '0);
    assign out_head     = out_mem_reg[out_rd_reg];

    assign magnitude_q2    = out_head.mag;
    assign direction_class = out_head.dir;
    assign frame_last      = out_head.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_reg    <= '0;
            out_rd_reg    <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            if (s3_valid_reg)
            begin
                out_wr_reg <= OUT_AW'(out_wr_reg + OUT_AW'(1));
            end
            if (out_pop)
            begin
                out_rd_reg <= OUT_AW'(out_rd_reg + OUT_AW'(1));
            end
            if (s3_valid_reg && !out_pop)
            begin
                out_count_reg <= (OUT_AW+1)'(out_count_reg + (OUT_AW+1)'(1));
            end
            else if (out_pop && !s3_valid_reg)
            begin
                out_count_reg <= (OUT_AW+1)'(out_count_reg - (OUT_AW+1)'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg)
        begin
            out_mem_reg[out_wr_reg] <= '{mag: MAG_W'(s3_mag_reg), dir: dir_c,
                                         last: s3_last_reg};
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sobel_gradient_direction.sv
// Top level of the streaming 3x3 Sobel gradient and four-way direction block.
// Depends on sgd_pkg, sgd_front, sgd_queue, sgd_back and sgd_ram.
//
// Use: pixels of a square frame arrive in raster order on the pixel channel, padded to
// (W+2) by (W+2) positions, two padding columns after each row and two padding rows
// after the frame. A request is taken at a rising edge with pixel_valid high and
// pixel_stall low. Results leave on the result channel (magnitude_q2, direction_class,
// frame_last) at edges with result_valid high and result_stall low; one result is made
// for every padded position with row and column both at least two.
// Throughput: one request per cycle, set by the single read and write per cycle of the
// line store RAM; the front end keeps taking requests while results wait in an
// eight-entry output buffer, and only stalls once that buffer and the four-entry
// request queue have filled behind a stalled receiver.
// The frame width is written through cfg_valid and cfg_ready with frame_width as data;
// cfg_ready is high only while no request or result is in the block and no pixel is
// being offered. A write clamps the width to the range 3 to 1024, restarts the raster
// position and clears the window.
// Reset sets the width to 512, empties the queue and buffers and clears the window; the
// line store keeps whatever it held, which only feeds the windows of rows 0 and 1, and
// those rows make no result.
`default_nettype none

module sobel_gradient_direction (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [sgd_pkg::PIX_W-1:0] pixel,
    input  logic                      pixel_valid,
    output logic                      pixel_stall,
    output logic [sgd_pkg::MAG_W-1:0] magnitude_q2,
    output logic [sgd_pkg::DIR_W-1:0] direction_class,
    output logic                      frame_last,
    output logic                      result_valid,
    input  logic                      result_stall,
    input  logic [sgd_pkg::CNT_W-1:0] frame_width,
    input  logic                      cfg_valid,
    output logic                      cfg_ready
);

    import sgd_pkg::*;

    logic  cfg_write;
    logic  push;
    item_t push_item;
    logic  q_full;
    logic  q_valid;
    item_t q_item;
    logic  pop;
    logic  back_idle;

    // Configuration is only taken with the whole datapath drained and no pixel on offer,
    // so a request can never be taken in the same cycle as a width write.
    assign cfg_ready = !q_valid && back_idle && !pixel_valid;
    assign cfg_write = cfg_valid && cfg_ready;

    sgd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel       (pixel),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .cfg_write   (cfg_write),
        .frame_width (frame_width),
        .q_full      (q_full),
        .push        (push),
        .push_item   (push_item)
    );

    sgd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (q_valid),
        .head_item  (q_item)
    );

    sgd_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .restart         (cfg_write),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .pop             (pop),
        .idle            (back_idle),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .magnitude_q2    (magnitude_q2),
        .direction_class (direction_class),
        .frame_last      (frame_last)
    );

endmodule

`default_nettype wire

FILE: hdl/sgd_checker.sv
// Port-level checker for the Sobel gradient block, attached to the top level by bind.
// Depends on sgd_pkg and sobel_gradient_direction.
`default_nettype none

module sgd_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      pixel_valid,
    input logic                      pixel_stall,
    input logic                      result_valid,
    input logic                      result_stall,
    input logic [sgd_pkg::MAG_W-1:0] magnitude_q2,
    input logic [sgd_pkg::DIR_W-1:0] direction_class,
    input logic                      frame_last,
    input logic                      cfg_valid,
    input logic                      cfg_ready
);

    import sgd_pkg::*;

    // A waiting result holds still until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(magnitude_q2)
            && $stable(direction_class) && $stable(frame_last))
    else $error("stalled result changed");

    // No gradient at all must fall in the horizontal class.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (magnitude_q2 == '0) |-> (direction_class == DIR_HORIZONTAL))
    else $error("zero gradient not classed horizontal");

    // A width write is only taken with the block drained, so no result follows at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !result_valid)
    else $error("result appeared right after a width write");

    // Coming out of reset the block is empty and takes requests.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !pixel_stall && !result_valid && cfg_ready)
    else $error("block not empty after reset");

endmodule

bind sobel_gradient_direction sgd_checker u_sgd_checker (.*);

`default_nettype wire
